@@ rtl/core/gcd_pkg.sv @@
package gcd_pkg;

	// CORDIC iterations per chain
	localparam int CORDIC_STEPS = 32;

	// datapath widths
	localparam int XW = 35;         // x/y of every CORDIC chain, Q.30 signed
	localparam int ZW = 34;         // angle accumulators, Q.30 signed
	localparam int RW = 34;         // divider remainder

	// degree to radian divider: bits retired per stage and stage count
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = 8;
	localparam int QW         = DIV_BITS * DIV_STAGES;

	// register-stage count of one sine/cosine lane
	localparam int SC_LAT = 3 + DIV_STAGES + CORDIC_STEPS;

	typedef logic signed [XW-1:0] cx_t;
	typedef logic signed [ZW-1:0] cz_t;
	typedef logic signed [33:0]   deg_t;

	localparam deg_t TURN      = 34'sd3600000000;
	localparam deg_t HALF_TURN = 34'sd1800000000;
	localparam deg_t QTR_TURN  = 34'sd900000000;

	localparam logic [63:0]   PI_Q32   = 64'h3243F6A89;
	localparam logic [63:0]   DIV_HALF = 64'd3600000000;
	localparam logic [RW-1:0] DIV_D    = 34'd7200000000;

	localparam cx_t        GAIN_Q30    = 35'sh026DD3B6A;
	localparam cz_t        HALF_PI_Q30 = 34'sh06487ED51;
	localparam logic [31:0] PI_Q30     = 32'hC90FDAA2;

	localparam logic [22:0] RADIUS_RESET = 23'd6372795;

	// atan(2^-i) in Q.30, built from a Q.62 series at elaboration
	function automatic cz_t atan_q30(input int i);
		logic [63:0] v;
		logic [63:0] term;
		int e;
		if (i == 0) begin
			v = 64'h3243F6A8885A308D;
		end else begin
			v = '0;
			for (int k = 0; k < 32; k++) begin
				e = 62 - i * (2 * k + 1);
				if (e >= 0) begin
					term = (64'd1 << e) / 64'(2 * k + 1);
					v = k[0] ? v - term : v + term;
				end
			end
		end
		v = (v + 64'h80000000) >> 32;
		return cz_t'(v[ZW-1:0]);
	endfunction

endpackage

@@ rtl/core/gcd_sincos.sv @@
// angle in degrees*1e7 to sine and cosine, Q.30
module gcd_sincos import gcd_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic signed [32:0] ang,
	output cx_t               sn,
	output cx_t               cs
);

	// stage 1: wrap into [-180, 180)
	deg_t w1;
	deg_t m1;
	logic signed [31:0] m_s1;

	always_comb begin
		w1 = 34'(ang);
		if (w1 >= HALF_TURN)
			m1 = w1 - TURN;
		else if (w1 < -HALF_TURN)
			m1 = w1 + TURN;
		else
			m1 = w1;
	end

	always_ff @(posedge clk) begin
		if (en) m_s1 <= 32'(m1);
	end

	// stage 2: fold into [-90, 90], remember the negation
	deg_t w2;
	deg_t f2;
	logic neg2;
	logic [29:0] mag_s2;
	logic        sgn_s2;
	logic        neg_s2;

	always_comb begin
		w2   = 34'(m_s1);
		neg2 = 1'b0;
		f2   = w2;
		if (w2 > QTR_TURN) begin
			f2   = w2 - HALF_TURN;
			neg2 = 1'b1;
		end else if (w2 < -QTR_TURN) begin
			f2   = w2 + HALF_TURN;
			neg2 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= 30'(f2 < 0 ? -f2 : f2);
			sgn_s2 <= f2 < 0;
			neg_s2 <= neg2;
		end
	end

	// stage 3: scale by pi, rounding offset added ahead of the divide
	logic [63:0] num_s3;
	logic        sgn_s3;
	logic        neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= 64'(mag_s2) * PI_Q32 + DIV_HALF;
			sgn_s3 <= sgn_s2;
			neg_s3 <= neg_s2;
		end
	end

	// divide by 7.2e9, DIV_BITS quotient bits per stage
	logic [RW-1:0] dv_rem [DIV_STAGES];
	logic [63:0]   dv_num [DIV_STAGES];
	logic [QW-1:0] dv_q   [DIV_STAGES];
	logic          dv_sgn [DIV_STAGES];
	logic          dv_neg [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [RW-1:0] prem;
		logic [63:0]   pnum;
		logic [QW-1:0] pq;
		logic          psgn;
		logic          pneg;
		logic [RW-1:0] r;
		logic [QW-1:0] q;

		if (k == 0) begin : g_first
			assign prem = RW'(num_s3 >> QW);
			assign pnum = num_s3;
			assign pq   = '0;
			assign psgn = sgn_s3;
			assign pneg = neg_s3;
		end else begin : g_next
			assign prem = dv_rem[k-1];
			assign pnum = dv_num[k-1];
			assign pq   = dv_q[k-1];
			assign psgn = dv_sgn[k-1];
			assign pneg = dv_neg[k-1];
		end

		always_comb begin
			r = prem;
			q = pq;
			for (int j = 0; j < DIV_BITS; j++) begin
				r = {r[RW-2:0], pnum[QW-1-(k*DIV_BITS+j)]};
				q = {q[QW-2:0], 1'b0};
				if (r >= DIV_D) begin
					r    = r - DIV_D;
					q[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[k] <= r;
				dv_num[k] <= pnum;
				dv_q[k]   <= q;
				dv_sgn[k] <= psgn;
				dv_neg[k] <= pneg;
			end
		end
	end

	// rotation chain
	cx_t  rt_x [CORDIC_STEPS];
	cx_t  rt_y [CORDIC_STEPS];
	cz_t  rt_z [CORDIC_STEPS];
	logic rt_n [CORDIC_STEPS];

	cz_t zq;
	assign zq = cz_t'(dv_q[DIV_STAGES-1]);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam cz_t ATAN = atan_q30(i);
		cx_t  px;
		cx_t  py;
		cz_t  pz;
		logic pn;

		if (i == 0) begin : g_first
			assign px = GAIN_Q30;
			assign py = '0;
			assign pz = dv_sgn[DIV_STAGES-1] ? -zq : zq;
			assign pn = dv_neg[DIV_STAGES-1];
		end else begin : g_next
			assign px = rt_x[i-1];
			assign py = rt_y[i-1];
			assign pz = rt_z[i-1];
			assign pn = rt_n[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (pz >= 0) begin
					rt_x[i] <= px - (py >>> i);
					rt_y[i] <= py + (px >>> i);
					rt_z[i] <= pz - ATAN;
				end else begin
					rt_x[i] <= px + (py >>> i);
					rt_y[i] <= py - (px >>> i);
					rt_z[i] <= pz + ATAN;
				end
				rt_n[i] <= pn;
			end
		end
	end

	assign sn = rt_n[CORDIC_STEPS-1] ? -rt_y[CORDIC_STEPS-1] : rt_y[CORDIC_STEPS-1];
	assign cs = rt_n[CORDIC_STEPS-1] ? -rt_x[CORDIC_STEPS-1] : rt_x[CORDIC_STEPS-1];

endmodule

@@ rtl/core/gcd_vec.sv @@
// pipelined CORDIC vectoring: drives y to zero, accumulates the angle
module gcd_vec import gcd_pkg::*; (
	input  logic clk,
	input  logic en,
	input  cx_t  x0,
	input  cx_t  y0,
	input  cz_t  z0,
	output cx_t  x,
	output cz_t  z
);

	cx_t vx [CORDIC_STEPS];
	cx_t vy [CORDIC_STEPS];
	cz_t vz [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		localparam cz_t ATAN = atan_q30(i);
		cx_t px;
		cx_t py;
		cz_t pz;

		if (i == 0) begin : g_first
			assign px = x0;
			assign py = y0;
			assign pz = z0;
		end else begin : g_next
			assign px = vx[i-1];
			assign py = vy[i-1];
			assign pz = vz[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (py >= 0) begin
					vx[i] <= px + (py >>> i);
					vy[i] <= py - (px >>> i);
					vz[i] <= pz + ATAN;
				end else begin
					vx[i] <= px - (py >>> i);
					vy[i] <= py + (px >>> i);
					vz[i] <= pz - ATAN;
				end
			end
		end
	end

	assign x = vx[CORDIC_STEPS-1];
	assign z = vz[CORDIC_STEPS-1];

endmodule

@@ rtl/core/great_circle_distance.sv @@
// Great-circle distance between two positions, atan2 form, fixed point.
// Input channel (in_valid/in_ready): two latitude/longitude pairs in signed
// degrees * 1e7; any bit pattern is taken, angles wrap modulo a full turn.
// Output channel (out_valid/out_ready): distance_m, whole meters, rounded.
// cfg_we/cfg_wdata write the sphere radius in meters; write only while idle.
// Throughput: one transfer per cycle on each side, sustained while out_ready is high.
// Pipeline: three CORDIC chains in series: sine/cosine rotation (after a
// pipelined 4-bit/stage degree-to-radian divide), numerator magnitude
// vectoring, and the final atan2 vectoring, plus the multiply/round stages
// between them.
// Stall: the whole pipeline holds while the last stage has a result that is
// not taken; in_ready drops in that case, nothing is lost or repeated.
// Reset clears every valid bit and loads the radius with 6372795 m.
module great_circle_distance import gcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [22:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        distance_m
);

	localparam int PW  = 2 * XW;
	localparam int LAT = SC_LAT + 10 + 2 * CORDIC_STEPS;

	// Q.60 product back to Q.30, half away from zero
	function automatic cx_t rnd30(input logic signed [PW-1:0] v);
		logic [PW-1:0] m;
		logic [PW-1:0] mr;
		m  = v < 0 ? PW'(-v) : PW'(v);
		mr = (m + (PW'(1) << 29)) >> 30;
		return v < 0 ? -$signed(mr[XW-1:0]) : $signed(mr[XW-1:0]);
	endfunction

	// radius register
	logic [22:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= RADIUS_RESET;
		else if (cfg_we)
			radius_q <= cfg_wdata;
	end

	// global advance: move unless the output holds an untaken result
	logic [LAT-1:0] vld_s;
	logic           en;

	assign en        = !vld_s[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-2:0], in_valid};
	end

	// sine/cosine lanes
	logic signed [32:0] dlon;
	cx_t sd, cd, s1, c1, s2, c2;

	assign dlon = 33'(first_longitude) - 33'(second_longitude);

	gcd_sincos u_dlon (.clk(clk), .en(en), .ang(dlon), .sn(sd), .cs(cd));
	gcd_sincos u_lat1 (.clk(clk), .en(en), .ang(33'(first_latitude)), .sn(s1), .cs(c1));
	gcd_sincos u_lat2 (.clk(clk), .en(en), .ang(33'(second_latitude)), .sn(s2), .cs(c2));

	// s1: first products
	logic signed [PW-1:0] c2cd_s1, c1s2_s1, c2sd_s1, s1s2_s1;
	cx_t sa_s1, ca_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c2cd_s1 <= PW'(c2) * PW'(cd);
			c1s2_s1 <= PW'(c1) * PW'(s2);
			c2sd_s1 <= PW'(c2) * PW'(sd);
			s1s2_s1 <= PW'(s1) * PW'(s2);
			sa_s1   <= s1;
			ca_s1   <= c1;
		end
	end

	// s2: round; cos(lat2)cos(dlon) is shared below
	cx_t c2cd_s2, c1s2_s2, b_s2, s1s2_s2, sa_s2, ca_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			c2cd_s2 <= rnd30(c2cd_s1);
			c1s2_s2 <= rnd30(c1s2_s1);
			b_s2    <= rnd30(c2sd_s1);
			s1s2_s2 <= rnd30(s1s2_s1);
			sa_s2   <= sa_s1;
			ca_s2   <= ca_s1;
		end
	end

	// s3: second products
	logic signed [PW-1:0] s1c_s3, c1c_s3;
	cx_t c1s2_s3, b_s3, s1s2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			s1c_s3  <= PW'(sa_s2) * PW'(c2cd_s2);
			c1c_s3  <= PW'(ca_s2) * PW'(c2cd_s2);
			c1s2_s3 <= c1s2_s2;
			b_s3    <= b_s2;
			s1s2_s3 <= s1s2_s2;
		end
	end

	// s4: numerator x and denominator
	cx_t a_s4, b_s4, den_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= c1s2_s3 - rnd30(s1c_s3);
			den_s4 <= s1s2_s3 + rnd30(c1c_s3);
			b_s4   <= b_s3;
		end
	end

	// s5: magnitudes into the vectoring chain
	cx_t ax_s5, by_s5, den_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s5  <= a_s4 < 0 ? -a_s4 : a_s4;
			by_s5  <= b_s4 < 0 ? -b_s4 : b_s4;
			den_s5 <= den_s4;
		end
	end

	// numerator magnitude; denominator rides alongside
	cx_t xm;
	cx_t den_d [CORDIC_STEPS];

	gcd_vec u_mag (
		.clk(clk), .en(en), .x0(ax_s5), .y0(by_s5), .z0('0), .x(xm), .z()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			den_d[0] <= den_s5;
			for (int i = 1; i < CORDIC_STEPS; i++)
				den_d[i] <= den_d[i-1];
		end
	end

	// s6/s7: undo the CORDIC gain
	logic signed [PW-1:0] gp_s6;
	cx_t den_s6, mag_s7, den_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			gp_s6  <= PW'(xm) * PW'(GAIN_Q30);
			den_s6 <= den_d[CORDIC_STEPS-1];
			mag_s7 <= XW'((gp_s6 + (PW'(1) << 29)) >>> 30);
			den_s7 <= den_s6;
		end
	end

	// atan2: a negative denominator starts a quarter turn ahead
	cx_t vx0, vy0;
	cz_t vz0;
	cz_t ang;

	always_comb begin
		if (den_s7 < 0) begin
			vx0 = mag_s7;
			vy0 = -den_s7;
			vz0 = HALF_PI_Q30;
		end else begin
			vx0 = den_s7;
			vy0 = mag_s7;
			vz0 = '0;
		end
	end

	gcd_vec u_ang (
		.clk(clk), .en(en), .x0(vx0), .y0(vy0), .z0(vz0), .x(), .z(ang)
	);

	// s8: clamp to [0, pi]; s9: scale by radius; s10: round to meters
	logic [31:0] zc_s8;
	logic [54:0] dp_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ang < 0)
				zc_s8 <= '0;
			else if (ang > cz_t'(PI_Q30))
				zc_s8 <= PI_Q30;
			else
				zc_s8 <= 32'(ang);
			dp_s9      <= 55'(zc_s8) * 55'(radius_q);
			distance_m <= 25'((dp_s9 + (55'd1 << 29)) >> 30);
		end
	end

	// checks
	logic [54:0] max_dist_w;
	assign max_dist_w = (55'(PI_Q30) * 55'(radius_q) + (55'd1 << 29)) >> 30;

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[0])
		else $error("accepted item did not enter the pipeline");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld_s))
		else $error("pipeline moved during output stall");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (55'(distance_m) <= max_dist_w))
		else $error("distance beyond half circumference");

endmodule

@@ dv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// drain with margin beyond the pipeline depth
	localparam int DRAIN_CYCLES = 140;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1530;
	localparam longint DEG_TURN = 64'sd3600000000;
	localparam longint DEG_HALF = 64'sd1800000000;
	localparam longint DEG_QTR  = 64'sd900000000;
	localparam longint Q30_GAIN = 64'sh26DD3B6A;
	localparam longint Q30_PI   = 64'shC90FDAA2;
	localparam longint Q30_HPI  = 64'sh6487ED51;

	typedef struct packed {
		logic signed [30:0] lat_a;
		logic signed [31:0] lon_a;
		logic signed [30:0] lat_b;
		logic signed [31:0] lon_b;
	} position_pair_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [22:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic signed [30:0] first_latitude;
	logic signed [31:0] first_longitude;
	logic signed [30:0] second_latitude;
	logic signed [31:0] second_longitude;
	logic               out_valid;
	logic               out_ready;
	logic [24:0]        distance_m;

	great_circle_distance dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_latitude   (first_latitude),
		.first_longitude  (first_longitude),
		.second_latitude  (second_latitude),
		.second_longitude (second_longitude),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.distance_m       (distance_m)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// Distance predictor: own arctangent table, own radius copy
	// ---------------------------------------------------------------
	longint       atan_q30_tab [32];
	logic [22:0]  radius_shadow;

	function automatic longint atan_entry(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		int sh;
		if (i == 0) begin
			acc = 64'h3243F6A8885A308D;
		end else begin
			acc = '0;
			for (int k = 0; k < 32; k++) begin
				sh = 62 - i * (2 * k + 1);
				if (sh >= 0) begin
					term = (64'd1 << sh) / 64'(2 * k + 1);
					acc = k[0] ? acc - term : acc + term;
				end
			end
		end
		return longint'((acc + 64'h80000000) >> 32);
	endfunction

	// product of two Q.30 values back to Q.30, half away from zero
	function automatic longint mul_q30(input longint p, input longint q);
		longint prod;
		prod = p * q;
		if (prod >= 0)
			return (prod + (64'sd1 << 29)) >>> 30;
		return -((-prod + (64'sd1 << 29)) >>> 30);
	endfunction

	function automatic void sin_cos_deg(input longint deg, output longint sn,
		output longint cs);
		longint      m;
		longint      ang;
		longint      cx;
		longint      cy;
		longint      tx;
		logic [63:0] mag;
		bit          flip;
		m    = deg % DEG_TURN;
		flip = 1'b0;
		if (m < 0)
			m += DEG_TURN;
		if (m >= DEG_HALF)
			m -= DEG_TURN;
		// fold beyond +-90 degrees, negate sin and cos afterwards
		if (m > DEG_QTR) begin
			m -= DEG_HALF;
			flip = 1'b1;
		end else if (m < -DEG_QTR) begin
			m += DEG_HALF;
			flip = 1'b1;
		end
		mag = (m < 0) ? 64'(-m) : 64'(m);
		ang = longint'((mag * 64'h3243F6A89 + 64'd3600000000) / 64'd7200000000);
		if (m < 0)
			ang = -ang;
		cx = Q30_GAIN;
		cy = 0;
		for (int i = 0; i < 32; i++) begin
			tx = cx;
			if (ang >= 0) begin
				cx  = cx - (cy >>> i);
				cy  = cy + (tx >>> i);
				ang = ang - atan_q30_tab[i];
			end else begin
				cx  = cx + (cy >>> i);
				cy  = cy - (tx >>> i);
				ang = ang + atan_q30_tab[i];
			end
		end
		sn = flip ? -cy : cy;
		cs = flip ? -cx : cx;
	endfunction

	function automatic logic [24:0] predict_distance(input position_pair_t pp);
		longint s1, c1, s2, c2, sd, cd, c2cd, num_a, num_b, den;
		longint vx, vy, vz, tx;
		logic [63:0] scaled;
		sin_cos_deg(longint'(pp.lon_a) - longint'(pp.lon_b), sd, cd);
		sin_cos_deg(longint'(pp.lat_a), s1, c1);
		sin_cos_deg(longint'(pp.lat_b), s2, c2);
		c2cd  = mul_q30(c2, cd);
		num_a = mul_q30(c1, s2) - mul_q30(s1, c2cd);
		num_b = mul_q30(c2, sd);
		den   = mul_q30(s1, s2) + mul_q30(c1, c2cd);
		// numerator magnitude by vectoring
		vx = (num_a < 0) ? -num_a : num_a;
		vy = (num_b < 0) ? -num_b : num_b;
		for (int i = 0; i < 32; i++) begin
			tx = vx;
			if (vy >= 0) begin
				vx = vx + (vy >>> i);
				vy = vy - (tx >>> i);
			end else begin
				vx = vx - (vy >>> i);
				vy = vy + (tx >>> i);
			end
		end
		vx = (vx * Q30_GAIN + (64'sd1 << 29)) >>> 30;
		// atan2(magnitude, den); negative den starts from a +90 degree turn
		if (den < 0) begin
			vy = -den;
			vz = Q30_HPI;
		end else begin
			vy = vx;
			vx = den;
			vz = 0;
		end
		for (int i = 0; i < 32; i++) begin
			tx = vx;
			if (vy >= 0) begin
				vx = vx + (vy >>> i);
				vy = vy - (tx >>> i);
				vz = vz + atan_q30_tab[i];
			end else begin
				vx = vx - (vy >>> i);
				vy = vy + (tx >>> i);
				vz = vz - atan_q30_tab[i];
			end
		end
		if (vz < 0)
			vz = 0;
		if (vz > Q30_PI)
			vz = Q30_PI;
		scaled = (64'(vz) * 64'(radius_shadow) + (64'd1 << 29)) >> 30;
		return scaled[24:0];
	endfunction

	// ---------------------------------------------------------------
	// Shared state between the stimulus, driver and monitor
	// ---------------------------------------------------------------
	position_pair_t pending_pairs [$];
	logic [24:0]    expected_dist [$];
	int  mismatches   = 0;
	int  checked      = 0;
	int  accepted     = 0;
	int  hold_request = 0;  // long receiver hold-off, in cycles
	bit  no_idle      = 1'b0;
	int  cycle_count  = 0;

	// ---------------------------------------------------------------
	// Driver: one transfer per handshake, random idle bursts
	// ---------------------------------------------------------------
	int send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		position_pair_t nxt;
		if (!arst_n) begin
			in_valid         <= 1'b0;
			first_latitude   <= '0;
			first_longitude  <= '0;
			second_latitude  <= '0;
			second_longitude <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				// prediction happens at the transfer, with the current radius
				expected_dist.push_back(predict_distance({first_latitude, first_longitude,
					second_latitude, second_longitude}));
				accepted++;
			end
			if (in_valid && !in_ready) begin
				// hold valid and payload until the transfer
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				nxt = pending_pairs.pop_front();
				in_valid         <= 1'b1;
				first_latitude   <= nxt.lat_a;
				first_longitude  <= nxt.lon_a;
				second_latitude  <= nxt.lat_b;
				second_longitude <= nxt.lon_b;
				if (!no_idle && $urandom_range(0, 15) == 0)
					send_gap = $urandom_range(1, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks each output transfer, drives out_ready stalls
	// ---------------------------------------------------------------
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [24:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				checked++;
				if (expected_dist.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected distance_m %0d", $realtime, distance_m);
				end else begin
					want = expected_dist.pop_front();
					if (distance_m !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: distance_m expected %0d got %0d",
								$realtime, want, distance_m);
					end
				end
			end
			if (hold_request > 0) begin
				// long hold-off so the pipeline fills and in_ready drops
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_dist.size());
			$display("great_circle_distance: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic add_pair(input longint la, input longint lo, input longint lb,
		input longint lob);
		position_pair_t pp;
		pp.lat_a = la[30:0];
		pp.lon_a = lo[31:0];
		pp.lat_b = lb[30:0];
		pp.lon_b = lob[31:0];
		pending_pairs.push_back(pp);
	endtask

	function automatic longint rand_lat();
		return longint'($urandom_range(0, 1800000000)) - DEG_QTR;
	endfunction

	function automatic longint rand_lon();
		return longint'($urandom_range(0, 32'd3600000000)) - DEG_HALF;
	endfunction

	function automatic longint near(input longint v, input int spread);
		return v + longint'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	task automatic add_random_pair();
		longint la, lo, lb, lob;
		int     kind;
		kind = $urandom_range(0, 9);
		la = rand_lat();
		lo = rand_lon();
		case (kind)
			0, 1, 2, 3: begin
				lb  = rand_lat();
				lob = rand_lon();
			end
			4, 5: begin
				// short track legs
				lb  = near(la, 20000);
				lob = near(lo, 20000);
			end
			6: begin
				// close to antipodal: denominator goes negative
				lb  = near(-la, 50000);
				lob = near(lo + DEG_HALF, 50000);
			end
			7: begin
				// same meridian, or longitudes mirrored about the prime meridian
				lb  = rand_lat();
				lob = $urandom_range(0, 1) ? lo : -lo;
			end
			default: begin
				// raw bit patterns, far out of range
				la  = longint'($signed(31'($urandom)));
				lo  = longint'($signed($urandom));
				lb  = longint'($signed(31'($urandom)));
				lob = longint'($signed($urandom));
			end
		endcase
		add_pair(la, lo, lb, lob);
	endtask

	task automatic write_radius(input logic [22:0] r);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		radius_shadow = r;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_pairs.size() > 0 || in_valid || expected_dist.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [22:0] radii [6];
		int          per_phase;
		for (int i = 0; i < 32; i++)
			atan_q30_tab[i] = atan_entry(i);
		radius_shadow = 23'd6372795;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at the reset radius
		add_pair(0, 0, 0, 0);
		add_pair(123456789, -987654321, 123456789, -987654321);
		add_pair(DEG_QTR, 0, -DEG_QTR, 0);               // pole to pole
		add_pair(0, 0, 0, DEG_HALF);                     // antipodal on equator
		add_pair(0, -DEG_HALF, 0, DEG_HALF);             // full-turn longitude gap
		add_pair(0, -DEG_HALF, 0, DEG_HALF - 1);
		add_pair(DEG_QTR, 1000, DEG_QTR, -1000);         // both at north pole
		add_pair(-DEG_QTR, 0, 0, 0);
		add_pair(450000000, 0, -450000000, DEG_HALF);    // antipodal, off equator
		add_pair(1, 0, 0, 0);
		add_pair(0, 1, 0, 0);
		add_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
		add_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
		add_pair(-1, -1, -1, -1);
		add_pair(DEG_QTR + 1, 0, DEG_QTR - 1, 0);        // latitude past a pole
		add_pair(0, 900000000, 0, -900000000);
		add_pair(0, 900000001, 0, -899999999);
		add_pair(DEG_QTR, DEG_HALF, -DEG_QTR, -DEG_HALF);
		add_pair(10000000, 20000000, -30000000, 64'sd2700000000 - DEG_TURN);
		add_pair(0, 0, 0, 1800000001);
		drain();

		radii[0] = 23'd6000000;
		radii[1] = 23'd7000000;
		radii[2] = 23'd0;
		radii[3] = 23'h7FFFFF;
		radii[4] = 23'($urandom_range(6000000, 7000000));
		radii[5] = 23'd6372795;
		per_phase = RANDOM_ITEMS / 6;
		for (int ph = 0; ph < 6; ph++) begin
			write_radius(radii[ph]);
			if (ph == 5)
				no_idle = 1'b1;
			for (int n = 0; n < per_phase; n++)
				add_random_pair();
			if (ph == 1)
				hold_request = 400;
			drain();
		end

		$display("%0d position pairs sent, %0d distances checked over 7 radius settings",
			accepted, checked);
		$display("covered: directed poles/antipodes/bit extremes, random tracks, stalls");
		if (mismatches == 0 && expected_dist.size() == 0) begin
			$display("great_circle_distance: match");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, expected_dist.size());
			$display("great_circle_distance: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/gcd_pkg.sv
rtl/core/gcd_sincos.sv
rtl/core/gcd_vec.sv
rtl/core/great_circle_distance.sv
dv/tb.sv
